[rtl/bbac_pkg.sv]
// ----------------------------------------------------------------------------
// bbac_pkg - shared definitions for the black border autocrop block
// Coordinate widths, request and register codes, and stream payload layout.
// ----------------------------------------------------------------------------
package bbac_pkg;

	localparam int COORD_BITS = 12;
	localparam int SIZE_BITS  = COORD_BITS + 1;

	localparam logic [23:0] COLOUR_MASK = 24'hFF_FFFF;

	localparam int PIX_BITS       = 32;
	localparam int SNAP_BITS      = 32;
	localparam int IN_DATA_BITS   = PIX_BITS + SNAP_BITS;
	localparam int IN_USER_BITS   = 1;
	localparam int CROP_BITS      = 2 * COORD_BITS + 2 * SIZE_BITS;
	localparam int OUT_DATA_BITS  = ((CROP_BITS + 7) / 8) * 8;
	localparam int OUT_USER_BITS  = 2;
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [IN_USER_BITS-1:0] {
		REQ_PIXEL = 1'b0,
		REQ_CLEAR = 1'b1
	} req_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEFT   = 2'd0,
		REG_TOP    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

	// last member sits in the lowest bits
	typedef struct packed {
		logic [SIZE_BITS-1:0]  height;
		logic [SIZE_BITS-1:0]  width;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] left;
	} crop_t;

	typedef struct packed {
		logic from_cache;
		logic all_black;
	} crop_flags_t;

endpackage

[rtl/black_border_autocrop.sv]
// ----------------------------------------------------------------------------
// black_border_autocrop - bounding box of non-black pixels in a region
// Streams region pixels in raster order and reports the cropped rectangle.
// ----------------------------------------------------------------------------
// Pixels of the configured region arrive in raster order on the s_ stream, one
// per clock while s_tready is high; a pixel is black when its low 24 bits are
// zero. On the pixel request marked tlast the block sends one rectangle on the
// m_ stream: the bounding box of the non-black pixels in absolute coordinates,
// or the whole region with all_black set. A nonzero snapshot number caches the
// first rectangle and replays it (from_cache set) until a clear request
// (tuser = 1) arrives. Every request passes through the input register before
// it updates the box and loads the result register, which offers the result on
// the m_ stream. The block sustains one request per clock unless m_tready stalls
// the result register; the per-pixel compare and update of the box registers
// sets this rate. The user must write the region registers on the cfg port only
// while the stream is idle; the block itself does not enforce this.
module black_border_autocrop
	import bbac_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]      cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_DATA_BITS-1:0]   s_tdata,   // pixel_value, snap_number
	input  logic [IN_USER_BITS-1:0]   s_tuser,   // req_type
	input  logic                      s_tlast,   // last_pixel
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_DATA_BITS-1:0]  m_tdata,   // crop_left, crop_top, crop_width, crop_height
	output logic [OUT_USER_BITS-1:0]  m_tuser    // all_black, from_cache
);

	logic [COORD_BITS-1:0] region_left_q, region_top_q;
	logic [SIZE_BITS-1:0]  region_width_q, region_height_q;

	logic                  valid_s1;
	req_t                  req_s1;
	logic [23:0]           pix_s1;
	logic                  last_s1;
	logic [SNAP_BITS-1:0]  snap_s1;

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COORD_BITS-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic                  any_q;
	logic                  cache_valid_q;
	crop_t                 cached_q;

	logic                  m_valid_q;
	crop_t                 crop_q;
	crop_flags_t           flags_q;

	logic                  advance, is_pix, hit, wrap, emit, snap_nz, use_cache;
	logic [SIZE_BITS-1:0]  col_inc;
	logic [COORD_BITS-1:0] min_col_n, max_col_n, min_row_n, max_row_n;
	logic                  any_n;
	crop_t                 res;
	crop_flags_t           res_flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_left_q   <= '0;
			region_top_q    <= '0;
			region_width_q  <= SIZE_BITS'(1);
			region_height_q <= SIZE_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT:   region_left_q   <= cfg_data[COORD_BITS-1:0];
				REG_TOP:    region_top_q    <= cfg_data[COORD_BITS-1:0];
				REG_WIDTH:  region_width_q  <= cfg_data;
				REG_HEIGHT: region_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register moves on whenever the result register has room
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= req_t'(s_tuser);
			pix_s1  <= s_tdata[23:0];
			last_s1 <= s_tlast;
			snap_s1 <= s_tdata[PIX_BITS +: SNAP_BITS];
		end
	end

	always_comb begin
		is_pix    = advance && (req_s1 == REQ_PIXEL);
		hit       = |(pix_s1 & COLOUR_MASK);
		col_inc   = {1'b0, col_q} + SIZE_BITS'(1);
		wrap      = (col_inc >= region_width_q) || (col_q == {COORD_BITS{1'b1}});
		min_col_n = (hit && (col_q < min_col_q)) ? col_q : min_col_q;
		max_col_n = (hit && (col_q > max_col_q)) ? col_q : max_col_q;
		min_row_n = (hit && (row_q < min_row_q)) ? row_q : min_row_q;
		max_row_n = (hit && (row_q > max_row_q)) ? row_q : max_row_q;
		any_n     = any_q || hit;
		emit      = is_pix && last_s1;
		snap_nz   = |snap_s1;
		use_cache = snap_nz && cache_valid_q;

		if (use_cache) begin
			res       = cached_q;
			res_flags = '{from_cache: 1'b1, all_black: 1'b0};
		end else if (any_n) begin
			res.left   = region_left_q + min_col_n;
			res.top    = region_top_q + min_row_n;
			res.width  = {1'b0, max_col_n} - {1'b0, min_col_n} + SIZE_BITS'(1);
			res.height = {1'b0, max_row_n} - {1'b0, min_row_n} + SIZE_BITS'(1);
			res_flags  = '{from_cache: 1'b0, all_black: 1'b0};
		end else begin
			res.left   = region_left_q;
			res.top    = region_top_q;
			res.width  = region_width_q;
			res.height = region_height_q;
			res_flags  = '{from_cache: 1'b0, all_black: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			min_col_q     <= '1;
			max_col_q     <= '0;
			min_row_q     <= '1;
			max_row_q     <= '0;
			any_q         <= 1'b0;
			cache_valid_q <= 1'b0;
			cached_q      <= '0;
		end else if (advance) begin
			if (req_s1 == REQ_CLEAR) begin
				cache_valid_q <= 1'b0;
			end else if (emit) begin
				// rearm the scan for the next frame
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '1;
				max_col_q <= '0;
				min_row_q <= '1;
				max_row_q <= '0;
				any_q     <= 1'b0;
				if (snap_nz && !cache_valid_q) begin
					cached_q      <= res;
					cache_valid_q <= 1'b1;
				end
			end else begin
				col_q     <= wrap ? '0 : col_inc[COORD_BITS-1:0];
				row_q     <= wrap ? row_q + COORD_BITS'(1) : row_q;
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				any_q     <= any_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			crop_q  <= res;
			flags_q <= res_flags;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_BITS'(crop_q);
	assign m_tuser  = flags_q;

endmodule

[rtl/bbac_checker.sv]
// ----------------------------------------------------------------------------
// bbac_checker - port-level checks for the black border autocrop block
// Watches the stream ports for latency, flow and flag consistency.
// ----------------------------------------------------------------------------
module bbac_checker
	import bbac_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [IN_USER_BITS-1:0]  s_tuser,
	input logic                     s_tlast,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic [OUT_USER_BITS-1:0] m_tuser
);

	// an empty result register never blocks new requests
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("s_tready low while no result is pending");

	// a result starting from empty comes from a last pixel request that passed through the input register
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |->
			$past(s_tvalid && s_tready && s_tlast && (s_tuser == REQ_PIXEL), 2))
		else $error("result without a matching last pixel request");

	// a replayed crop is never flagged all black
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("all_black and from_cache both set");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind black_border_autocrop bbac_checker u_bbac_checker (.*);
